>>> rtl/core/s9e_pkg.sv
// Shared types, constants and layout tables of the Simple9 encoder.
// No dependencies; imported by every module of the block.
package s9e_pkg;

  localparam int unsigned VALUE_W     = 28;  // payload bits of one stored value
  localparam int unsigned NUM_LAYOUTS = 9;   // selector codes 0..8
  localparam int unsigned BUF_DEPTH   = 28;  // values that fill one 28x1 word
  localparam int unsigned CLS_W       = 4;   // width of a layout index / selector
  localparam int unsigned CNT_W       = 5;   // holds 0..BUF_DEPTH

  // One classified input word as it travels from front to back.
  typedef struct packed {
    logic [VALUE_W-1:0] value;     // low 28 bits of the input value
    logic [CLS_W-1:0]   cls;       // narrowest layout whose width holds the value
    logic               too_wide;  // any of bits 31..28 set
    logic               last;      // final value of the stream
  } item_t;

  // Values per word for each selector.
  function automatic int unsigned lay_count(input int unsigned li);
    case (li)
      0: lay_count = 28;
      1: lay_count = 14;
      2: lay_count = 9;
      3: lay_count = 7;
      4: lay_count = 5;
      5: lay_count = 4;
      6: lay_count = 3;
      7: lay_count = 2;
      default: lay_count = 1;
    endcase
  endfunction

  // Bits per value for each selector.
  function automatic int unsigned lay_width(input int unsigned li);
    case (li)
      0: lay_width = 1;
      1: lay_width = 2;
      2: lay_width = 3;
      3: lay_width = 4;
      4: lay_width = 5;
      5: lay_width = 7;
      6: lay_width = 9;
      7: lay_width = 14;
      default: lay_width = 28;
    endcase
  endfunction

endpackage

>>> rtl/core/simple9_encoder_top.sv
// Flow: an accepted word is registered in the queue before the back end sees it; a result
//   reaches the master side through the output register when the back end takes or packs it.
// Throughput: one value per cycle while no word is packed and the output register is free;
//   the back end takes no new value while it packs a word, and a flush packs until it is empty.
// Reset (rst, synchronous): clears queue pointers, buffer count, state and output
//   valid; buffered values are not cleared and need no clearing pass.
// Top level of the Simple9 encoder; depends on s9e_pkg, s9e_front, s9e_queue, s9e_back.
module simple9_encoder_top
  import s9e_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Slave side: input values.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last value of the stream
  // Master side: packed words.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] packed_word (selector in 31..28)
  output logic        m_tlast,   // end_of_stream
  output logic        m_tuser    // [0] too_wide
);

  item_t front_item;
  item_t back_item;
  logic  q_valid;
  logic  q_ready;

  // Classify: flag overwide values and find each value's narrowest layout.
  s9e_front u_front (
    .value (s_tdata),
    .last  (s_tlast),
    .item  (front_item)
  );

  // Decouple acceptance from packing so either side may stall on its own.
  s9e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (back_item)
  );

  // Buffer values, pick layouts, pack and emit words through an output register.
  s9e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (back_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata),
    .out_eos   (m_tlast),
    .out_wide  (m_tuser)
  );

endmodule

>>> rtl/core/s9e_front.sv
// Front end of the Simple9 encoder: checks and classifies each input word.
// Depends on s9e_pkg.
module s9e_front
  import s9e_pkg::*;
(
  input  logic [31:0] value,
  input  logic        last,
  output item_t       item
);

  logic [CLS_W-1:0] cls;

  // Find the narrowest layout width that holds the value; scan widest first.
  always_comb begin
    cls = CLS_W'(NUM_LAYOUTS - 1);
    for (int li = NUM_LAYOUTS - 1; li >= 0; li--) begin
      if ((value[VALUE_W-1:0] >> lay_width(li)) == '0) begin
        cls = CLS_W'(li);
      end
    end
  end

  assign item.value    = value[VALUE_W-1:0];
  assign item.cls      = cls;
  assign item.too_wide = |value[31:VALUE_W];
  assign item.last     = last;

endmodule

>>> rtl/core/s9e_queue.sv
// Short queue of classified words between the front and back of the encoder.
// Depends on s9e_pkg for the item type.
module s9e_queue
  import s9e_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  assign push_ready = (fill != FW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + FW'(1);
        2'b01:   fill <= fill - FW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/core/s9e_back.sv
// Back end of the Simple9 encoder: buffers values, picks layouts and packs words.
// Depends on s9e_pkg; fed by s9e_queue.
module s9e_back
  import s9e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  item_t       pop_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        out_eos,
  output logic        out_wide
);

  typedef enum logic [1:0] {
    ST_TAKE = 2'b01,
    ST_PACK = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               flush, flush_next;
  logic [VALUE_W-1:0] buf_val [BUF_DEPTH];
  logic [CLS_W-1:0]   buf_cls [BUF_DEPTH];
  logic [VALUE_W-1:0] shift_val [BUF_DEPTH];
  logic [CLS_W-1:0]   shift_cls [BUF_DEPTH];

  logic [NUM_LAYOUTS-1:0] fits;
  logic [VALUE_W-1:0]     cand [NUM_LAYOUTS];
  logic [CLS_W-1:0]       sel;
  logic [CNT_W-1:0]       pack_cnt;
  logic                   out_free;
  logic                   load, ld_eos, ld_wide, wr_en, shift_en;
  logic [31:0]            ld_word;

  assign out_free  = !out_valid || out_ready;
  assign pop_ready = (state == ST_TAKE) && out_free;

  // Layout check: count must be available and every covered value must fit.
  always_comb begin
    for (int li = 0; li < NUM_LAYOUTS; li++) begin
      fits[li] = (lay_count(li) <= 32'(count));
      for (int j = 0; j < BUF_DEPTH; j++) begin
        if (j < lay_count(li) && buf_cls[j] > CLS_W'(li)) begin
          fits[li] = 1'b0;
        end
      end
    end
  end

  // Take the first fitting layout; the widest always fits on a nonempty buffer.
  always_comb begin
    logic found;
    found = 1'b0;
    sel   = CLS_W'(NUM_LAYOUTS - 1);
    for (int li = 0; li < NUM_LAYOUTS; li++) begin
      if (!found && fits[li]) begin
        sel   = CLS_W'(li);
        found = 1'b1;
      end
    end
  end

  assign pack_cnt = CNT_W'(lay_count(32'(sel)));

  // Candidate payload for each layout, earliest value in the highest field.
  always_comb begin
    for (int li = 0; li < NUM_LAYOUTS; li++) begin
      cand[li] = '0;
      for (int j = 0; j < BUF_DEPTH; j++) begin
        if (j < lay_count(li)) begin
          cand[li] = cand[li] | VALUE_W'(32'(buf_val[j])
                     << ((lay_count(li) - 1 - j) * lay_width(li)));
        end
      end
    end
  end

  // Drop the packed values from the front of the buffer.
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      shift_val[i] = buf_val[i];
      shift_cls[i] = buf_cls[i];
      for (int li = 0; li < NUM_LAYOUTS; li++) begin
        if (sel == CLS_W'(li) && (i + lay_count(li)) < BUF_DEPTH) begin
          shift_val[i] = buf_val[i + lay_count(li)];
          shift_cls[i] = buf_cls[i + lay_count(li)];
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    flush_next = flush;
    load       = 1'b0;
    ld_word    = '0;
    ld_eos     = 1'b0;
    ld_wide    = 1'b0;
    wr_en      = 1'b0;
    shift_en   = 1'b0;
    unique case (state)
      ST_TAKE: begin
        if (pop_valid && out_free) begin
          if (pop_item.too_wide) begin
            load    = 1'b1;
            ld_wide = 1'b1;
            ld_eos  = pop_item.last && (count == '0);
            if (pop_item.last && count != '0) begin
              flush_next = 1'b1;
              state_next = ST_PACK;
            end
          end else begin
            wr_en      = 1'b1;
            count_next = count + CNT_W'(1);
            if (pop_item.last) begin
              flush_next = 1'b1;
              state_next = ST_PACK;
            end else if (count == CNT_W'(BUF_DEPTH - 1)) begin
              flush_next = 1'b0;
              state_next = ST_PACK;
            end
          end
        end
      end
      ST_PACK: begin
        if (out_free) begin
          load       = 1'b1;
          shift_en   = 1'b1;
          ld_word    = {sel, cand[sel]};
          count_next = count - pack_cnt;
          ld_eos     = flush && (count_next == '0);
          if (!flush || count_next == '0) begin
            flush_next = 1'b0;
            state_next = ST_TAKE;
          end
        end
      end
      default: begin
        state_next = ST_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_TAKE;
      count     <= '0;
      flush     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      flush <= flush_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= ld_word;
      out_eos  <= ld_eos;
      out_wide <= ld_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      buf_val <= shift_val;
      buf_cls <= shift_cls;
    end else if (wr_en) begin
      buf_val[count] <= pop_item.value;
      buf_cls[count] <= pop_item.cls;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(BUF_DEPTH))
    else $error("buffer count above depth");

  a_pack_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_PACK |-> count != '0)
    else $error("packing from an empty buffer");

  a_flush_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PACK && flush) |=> (state == ST_PACK || count == '0))
    else $error("flush ended with values left");

  a_eos_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_eos) |-> count == '0)
    else $error("end of stream shown with values pending");

endmodule

>>> dv/simple9_encoder_top_test.sv
// Self-checking testbench for simple9_encoder_top: random and directed value streams,
// with expected packed words predicted cycle-free from a model of the encoding rules.
// Depends on s9e_pkg and the simple9_encoder_top RTL.
module simple9_encoder_top_test;
  import s9e_pkg::*;

  // Stall-free watchdog window; must exceed the long receiver hold-off below.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned MAX_LAYOUT     = NUM_LAYOUTS - 1;

  // One input word: value plus end-of-stream marker.
  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } in_word_t;

  // One packed word as seen on the master side.
  typedef struct packed {
    logic [31:0] word;
    logic        eos;
    logic        wide;
  } out_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'h0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  simple9_encoder_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Words waiting to be offered, and packed words the encoder still owes us.
  in_word_t  pending_inputs[$];
  out_word_t expected_words[$];

  // Shadow copy of the encoder's value buffer.
  logic [VALUE_W-1:0] held_vals[BUF_DEPTH];
  int                 held_cnt = 0;

  int err_count      = 0;
  int words_queued   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;
  bit hold_taken     = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Bits per value for layout li; the value count per word is 28 / bits.
  function automatic int layout_bits(input int li);
    case (li)
      0: layout_bits = 1;
      1: layout_bits = 2;
      2: layout_bits = 3;
      3: layout_bits = 4;
      4: layout_bits = 5;
      5: layout_bits = 7;
      6: layout_bits = 9;
      7: layout_bits = 14;
      default: layout_bits = 28;
    endcase
  endfunction

  // Pack one word from the front of the shadow buffer and drop the values it took.
  task automatic pack_front(output logic [31:0] word);
    int  li;
    int  bits;
    int  per;
    bit  found;
    bit  fits;
    li = MAX_LAYOUT;
    found = 1'b0;
    // Take the first layout whose next count values all fit its width.
    for (int k = 0; k < NUM_LAYOUTS; k++) begin
      if (!found) begin
        bits = layout_bits(k);
        per = VALUE_W / bits;
        if (per <= held_cnt) begin
          fits = 1'b1;
          for (int j = 0; j < per; j++) begin
            if ((held_vals[j] >> bits) != 0) fits = 1'b0;
          end
          if (fits) begin
            li = k;
            found = 1'b1;
          end
        end
      end
    end
    bits = layout_bits(li);
    per = VALUE_W / bits;
    if (per > held_cnt) per = held_cnt;
    // Earlier values land in the higher bits.
    word = 32'h0;
    for (int j = 0; j < per; j++) word = (word << bits) | {4'b0, held_vals[j]};
    word[31:28] = li[CLS_W-1:0];
    for (int j = 0; j + per < held_cnt; j++) held_vals[j] = held_vals[j + per];
    held_cnt -= per;
  endtask

  // Predict the packed words caused by one accepted input word.
  task automatic encode_value(input in_word_t w);
    out_word_t res;
    int        n;
    n = 0;
    if (w.value[31:28] != 4'h0) begin
      // Too wide: drop the value and flag it ahead of any flush.
      res.word = 32'h0;
      res.eos = 1'b0;
      res.wide = 1'b1;
      expected_words.push_back(res);
      n++;
    end else if (held_cnt < BUF_DEPTH) begin
      held_vals[held_cnt] = w.value[VALUE_W-1:0];
      held_cnt++;
    end
    res.eos = 1'b0;
    res.wide = 1'b0;
    if (w.last) begin
      while (held_cnt > 0 && n < BUF_DEPTH) begin
        pack_front(res.word);
        expected_words.push_back(res);
        n++;
      end
      held_cnt = 0;
      // Mark the final word of the flush, even when it is the error word.
      if (n > 0) begin
        res = expected_words.pop_back();
        res.eos = 1'b1;
        expected_words.push_back(res);
      end
    end else if (held_cnt >= BUF_DEPTH) begin
      pack_front(res.word);
      expected_words.push_back(res);
    end
  endtask

  // Driver: offer the next pending word, or idle at the phase's rate.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_inputs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_inputs[0].value;
        s_tlast  <= pending_inputs[0].last;
        void'(pending_inputs.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on every accepted input word, check every accepted result.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && s_tvalid && s_tready) encode_value('{value: s_tdata, last: s_tlast});
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word got %h eos %b wide %b", $time, m_tdata, m_tlast,
                 m_tuser);
        err_count++;
      end else begin
        want = expected_words.pop_front();
        if (m_tdata !== want.word || m_tlast !== want.eos || m_tuser !== want.wide) begin
          $display("%0t: mismatch word exp %h got %h eos exp %b got %b wide exp %b got %b",
                   $time, want.word, m_tdata, want.eos, m_tlast, want.wide, m_tuser);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic add_word(input logic [31:0] value, input logic last);
    pending_inputs.push_back('{value: value, last: last});
    words_queued++;
  endtask

  // Queue one stream of len values; most share a width class so every layout shows up.
  task automatic add_stream(input int len);
    int          base_w;
    int          w;
    int          roll;
    logic [31:0] v;
    base_w = layout_bits($urandom_range(MAX_LAYOUT));
    if ($urandom_range(9) == 0) base_w = 0;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        // Too wide: force at least one of the top four bits.
        v = $urandom;
        if (v[31:28] == 4'h0) v[31:28] = 4'($urandom_range(15, 1));
      end else begin
        w = (roll < 75) ? base_w : $urandom_range(VALUE_W);
        v = $urandom;
        v = (w == 0) ? 32'h0 : (v & ((32'h1 << w) - 1));
      end
      add_word(v, i == len - 1);
    end
  endtask

  // Fill the driver with random streams until the phase count is reached, then drain.
  task automatic run_phase(input int sender_idle, input int recv_stall, input int n_words);
    int target;
    int len;
    @(negedge clk);
    send_idle_pct  = sender_idle;
    recv_stall_pct = recv_stall;
    target = words_queued + n_words;
    while (words_queued < target) begin
      if ($urandom_range(3) == 0) len = $urandom_range(70, 28);
      else len = $urandom_range(27, 1);
      // Trim the final stream so the phase sends exactly its share.
      if (len > target - words_queued) len = target - words_queued;
      add_stream(len);
    end
    drain();
  endtask

  // Wait until every word is sent and every result has come back.
  task automatic drain();
    while (!(pending_inputs.size() == 0 && !s_tvalid && expected_words.size() == 0))
      @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: a too-wide last value on an empty buffer flushes just the error word.
    add_word(32'hFFFF_FFFF, 1'b1);
    // Widest legal value alone takes the 1x28 layout.
    add_word(32'h0FFF_FFFF, 1'b1);
    // Single top bits set are each too wide.
    add_word(32'h1000_0000, 1'b0);
    add_word(32'h8000_0000, 1'b0);
    add_word(32'h0000_0000, 1'b1);
    // Flush with few values: three small values settle on 3x9.
    add_word(32'h1, 1'b0);
    add_word(32'h2, 1'b0);
    add_word(32'h3, 1'b1);
    // Error word first, then the flush of what was pending.
    add_word(32'h5, 1'b0);
    add_word(32'h7F, 1'b0);
    add_word(32'hE000_0000, 1'b1);
    // Two 14-bit values.
    add_word(32'h3FFF, 1'b0);
    add_word(32'h3FFF, 1'b1);
    // Seven 4-bit values.
    for (int i = 0; i < 7; i++) add_word(32'hF - i, i == 6);
    // Five 5-bit values, then a 9-bit one.
    for (int i = 0; i < 5; i++) add_word(32'h1F - i, 1'b0);
    add_word(32'h1FF, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();

    // Random phases: no idling, idle sender, stalling receiver, both lightly.
    run_phase(0, 0, 60);
    run_phase(53, 0, 50);
    run_phase(0, 53, 50);
    run_phase(11, 11, 40);

    // Back-pressure: hold off the receiver while the sender keeps offering words.
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    for (int i = 0; i < 40; i++) add_word($urandom_range(3), i == 39);
    drain();
    hold_req = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
